@@ hw/rtl/psched_pkg.sv @@
package psched_pkg;

  // Sizing of the task table and the time base.
  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int PRIO_W    = 8;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // One task record as kept in the task table.
  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] remain;
  } rec_t;

  // Write request into the task table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    rec_t              data;
  } mem_wr_t;

endpackage

@@ hw/rtl/psched_mem.sv @@
module psched_mem
  import psched_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output rec_t              rd_data
);

  rec_t mem [MAX_TASKS];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/preemptive_priority_scheduler_top.sv @@
// Preemptive highest-priority-first scheduler. A load transaction (tuser = 0) writes one
// task record into its slot and then loads its result into the output register. A tick
// transaction (tuser = 1) scans all 16 slots through the single read port of the task
// table, one slot per cycle, then updates the chosen task. Its steps are the scan, the last
// table read, the update step and the load of the output register. The block accepts the
// next transaction only once the result is in the output register. Only one transaction
// is in work at a time; s_tready is high while the block waits for input. A finished
// result sits in the output register until taken, and the block stalls before its last
// step if that register is still full. Time saturates at its maximum value.
module preemptive_priority_scheduler_top
  import psched_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [3:0] slot, [19:4] arrival, [35:20] burst, [43:36] prio, [47:44] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [3:0] running_slot, [4] idle, [5] finished, [21:6] completion_time,
  // [37:22] turnaround, [53:38] waiting, [54] all_done, [55] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [2:0]           state;
  logic [SLOT_W-1:0]    idx;
  logic                 cand_vld;
  logic [SLOT_W-1:0]    cand_idx;
  logic                 best_valid;
  logic [SLOT_W-1:0]    best_slot;
  rec_t                 best_rec;
  logic [TIME_BITS-1:0] now;
  logic [MAX_TASKS-1:0] loaded;
  logic [MAX_TASKS-1:0] done;
  logic                 is_load;
  logic [SLOT_W-1:0]    load_slot;
  logic                 fin;
  logic [TIME_BITS-1:0] end_time;
  logic [TIME_BITS-1:0] tat;

  mem_wr_t              wr;
  rec_t                 rd_data;

  // Input payload fields.
  logic [SLOT_W-1:0]    in_slot;
  logic [TIME_BITS-1:0] in_arrival;
  logic [TIME_BITS-1:0] in_burst;
  logic [PRIO_W-1:0]    in_prio;
  logic                 in_accept;

  assign in_slot    = s_tdata[3:0];
  assign in_arrival = s_tdata[19:4];
  assign in_burst   = s_tdata[35:20];
  assign in_prio    = s_tdata[43:36];
  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;

  psched_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Candidate check for the slot whose record arrived from the table this cycle.
  logic cand_elig;
  logic cand_take;

  assign cand_elig = cand_vld && loaded[cand_idx] && !done[cand_idx] && (rd_data.arrival <= now);
  assign cand_take = cand_elig &&
                     (!best_valid || (rd_data.prio > best_rec.prio) ||
                      ((rd_data.prio == best_rec.prio) && (rd_data.arrival < best_rec.arrival)));

  // Update step arithmetic for the chosen task.
  logic [TIME_BITS-1:0] end_next;
  logic [TIME_BITS-1:0] remain_next;

  assign end_next    = (now == TIME_MAX) ? now : now + 1'b1;
  assign remain_next = best_rec.remain - 1'b1;

  // Table writes come from a load or from the decrement of the running task.
  always_comb begin
    wr      = '0;
    wr.addr = best_slot;
    wr.data = best_rec;
    wr.data.remain = remain_next;
    if (state == ST_IDLE) begin
      wr.en           = in_accept && (s_tuser == FUNC_LOAD) &&
                        ({1'b0, in_slot} < (SLOT_W+1)'(MAX_TASKS));
      wr.addr         = in_slot;
      wr.data.prio    = in_prio;
      wr.data.arrival = in_arrival;
      wr.data.burst   = in_burst;
      wr.data.remain  = in_burst;
    end else if (state == ST_UPD) begin
      wr.en = best_valid;
    end
  end

  // Sequencer and slot bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      cand_vld   <= 1'b0;
      best_valid <= 1'b0;
      now        <= '0;
      loaded     <= '0;
      done       <= '0;
      is_load    <= 1'b0;
      fin        <= 1'b0;
    end else begin
      if (cand_take) begin
        best_valid <= 1'b1;
        best_slot  <= cand_idx;
        best_rec   <= rd_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            load_slot  <= in_slot;
            idx        <= '0;
            best_valid <= 1'b0;
            fin        <= 1'b0;
            if (s_tuser == FUNC_LOAD) begin
              is_load <= 1'b1;
              state   <= ST_FIN;
              if (wr.en) begin
                loaded[in_slot] <= 1'b1;
                done[in_slot]   <= (in_burst == '0);
              end
            end else begin
              is_load <= 1'b0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cand_vld <= 1'b1;
          cand_idx <= idx;
          idx      <= idx + 1'b1;
          if (idx == SLOT_W'(MAX_TASKS - 1)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          cand_vld <= 1'b0;
          state    <= ST_UPD;
        end
        ST_UPD: begin
          now      <= end_next;
          end_time <= end_next;
          tat      <= end_next - best_rec.arrival;
          if (best_valid && (remain_next == '0)) begin
            fin             <= 1'b1;
            done[best_slot] <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result assembly.
  logic [TIME_BITS-1:0] wt;
  logic                 all_done;
  logic [OUT_DATA_W-1:0] res;

  assign wt       = (tat >= best_rec.burst) ? tat - best_rec.burst : '0;
  assign all_done = ~|(loaded & ~done);

  always_comb begin
    res     = '0;
    res[54] = all_done;
    if (is_load) begin
      res[3:0] = load_slot;
      res[4]   = 1'b1;
    end else begin
      res[4] = !best_valid;
      if (best_valid) begin
        res[3:0] = best_slot;
      end
      if (fin) begin
        res[5]     = 1'b1;
        res[21:6]  = end_time;
        res[37:22] = tat;
        res[53:38] = wt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Time never runs backward.
  a_now_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (now >= $past(now)))
    else $error("scheduler time decreased");

  // A slot can only be finished if it holds a task.
  a_done_loaded: assert property (@(posedge clk) disable iff (rst)
    ((done & ~loaded) == '0))
    else $error("finished slot is not loaded");

  // The chosen task is loaded and unfinished when it is updated.
  a_best_elig: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UPD) && best_valid) |-> (loaded[best_slot] && !done[best_slot]))
    else $error("chosen task not eligible");

  // A completion is never reported on an idle result.
  a_fin_not_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> !m_tdata[4])
    else $error("finished flag on idle result");
`endif

endmodule

@@ tb/preemptive_priority_scheduler_top_tb.sv @@
module preemptive_priority_scheduler_top_tb;
  import psched_pkg::*;

  // One scheduler result as it leaves the block.
  typedef struct packed {
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic              finished;
    logic [15:0]       completion;
    logic [15:0]       turnaround;
    logic [15:0]       waiting;
    logic              all_done;
  } result_t;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the task table and the scheduler clock.
  logic                 task_loaded  [MAX_TASKS];
  logic                 task_done    [MAX_TASKS];
  logic [TIME_BITS-1:0] task_arrival [MAX_TASKS];
  logic [TIME_BITS-1:0] task_burst   [MAX_TASKS];
  logic [TIME_BITS-1:0] task_remain  [MAX_TASKS];
  logic [PRIO_W-1:0]    task_prio    [MAX_TASKS];
  logic [TIME_BITS-1:0] sched_now;

  result_t pending_results[$];

  logic no_gaps = 1'b0;
  int   items_sent = 0;
  int   n_loads = 0;
  int   n_ticks = 0;
  int   n_finish = 0;
  int   n_idle = 0;
  int   n_checked = 0;
  int   err_cnt = 0;

  preemptive_priority_scheduler_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // True when no loaded, unfinished task has arrived by the given time.
  function automatic logic all_settled(input logic [TIME_BITS-1:0] horizon);
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (task_loaded[k] && !task_done[k] && task_arrival[k] <= horizon) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one transaction to the shadow table and returns the result it causes.
  function automatic result_t schedule_step(input logic func, input logic [SLOT_W-1:0] slot,
                                            input logic [TIME_BITS-1:0] arr,
                                            input logic [TIME_BITS-1:0] bur,
                                            input logic [PRIO_W-1:0] pri);
    result_t              r;
    int                   pick;
    logic [TIME_BITS-1:0] end_t;
    logic [TIME_BITS-1:0] tat;
    r = '0;
    pick = -1;
    if (func == FUNC_LOAD) begin
      task_loaded[slot]  = 1'b1;
      task_arrival[slot] = arr;
      task_burst[slot]   = bur;
      task_remain[slot]  = bur;
      task_prio[slot]    = pri;
      task_done[slot]    = (bur == '0);
      r.running_slot = slot;
      r.idle         = 1'b1;
      r.all_done     = all_settled(TIME_MAX);
      n_loads++;
      return r;
    end
    // Highest priority wins; on equal priority the earlier arrival, then the lower slot.
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (task_loaded[k] && !task_done[k] && task_arrival[k] <= sched_now) begin
        if (pick < 0 || task_prio[k] > task_prio[pick] ||
            (task_prio[k] == task_prio[pick] && task_arrival[k] < task_arrival[pick]))
          pick = k;
      end
    end
    end_t = (sched_now < TIME_MAX) ? sched_now + 1'b1 : TIME_MAX;
    if (pick < 0) begin
      r.idle = 1'b1;
      n_idle++;
    end else begin
      r.running_slot = pick[SLOT_W-1:0];
      if (task_remain[pick] != '0) task_remain[pick] = task_remain[pick] - 1'b1;
      if (task_remain[pick] == '0) begin
        task_done[pick] = 1'b1;
        tat = end_t - task_arrival[pick];
        r.finished   = 1'b1;
        r.completion = end_t;
        r.turnaround = tat;
        r.waiting    = (tat >= task_burst[pick]) ? tat - task_burst[pick] : '0;
        n_finish++;
      end
    end
    sched_now = end_t;
    n_ticks++;
    r.all_done = all_settled(TIME_MAX);
    return r;
  endfunction

  // Presents one transaction after a random gap (none if no_gaps) and records its expected result.
  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_BITS-1:0] arr, input logic [TIME_BITS-1:0] bur,
                           input logic [PRIO_W-1:0] pri);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(IN_DATA_W-44){1'b0}}, pri, bur, arr, slot};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(schedule_step(func, slot, arr, bur, pri));
    items_sent++;
  endtask

  // A tick carries random payload, which the block must ignore.
  task automatic send_tick();
    send_item(FUNC_TICK, SLOT_W'($urandom), TIME_BITS'($urandom), TIME_BITS'($urandom),
              PRIO_W'($urandom));
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_bad(input string what, input result_t e, input result_t g);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR %s: exp slot=%0d idle=%b fin=%b ct=%0d tat=%0d wt=%0d done=%b",
               what, e.running_slot, e.idle, e.finished, e.completion, e.turnaround,
               e.waiting, e.all_done);
      $display("  got slot=%0d idle=%b fin=%b ct=%0d tat=%0d wt=%0d done=%b",
               g.running_slot, g.idle, g.finished, g.completion, g.turnaround,
               g.waiting, g.all_done);
    end
  endtask

  // Loads a handful of tasks due near now, then ticks until they have run, at most 60 ticks.
  task automatic run_batch();
    int                   ntask;
    int                   guard;
    logic [SLOT_W-1:0]    slot;
    logic [PRIO_W-1:0]    pri;
    logic [TIME_BITS-1:0] arr;
    ntask = $urandom_range(1, 6);
    for (int k = 0; k < ntask; k++) begin
      slot = SLOT_W'($urandom_range(0, MAX_TASKS - 1));
      case ($urandom_range(0, 3))
        0: pri = $urandom_range(0, 1) ? '1 : '0;
        1: pri = 8'h40 + PRIO_W'($urandom_range(0, 1));
        default: pri = PRIO_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0 && sched_now > 3)
        arr = sched_now - TIME_BITS'($urandom_range(0, 3));
      else
        arr = sched_now + TIME_BITS'($urandom_range(0, 5));
      send_item(FUNC_LOAD, slot, arr, TIME_BITS'($urandom_range(1, 6)), pri);
      // Occasional ticks in between let newcomers preempt running work.
      if ($urandom_range(0, 2) == 0) send_tick();
    end
    guard = 0;
    while (!all_settled(sched_now + 6) && guard < 60) begin
      send_tick();
      guard++;
    end
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  // Retires every pending task by reloading it with a zero burst.
  task automatic retire_stale();
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (task_loaded[k] && !task_done[k])
        send_item(FUNC_LOAD, k[SLOT_W-1:0], TIME_BITS'($urandom), '0, PRIO_W'($urandom));
    end
  endtask

  task automatic test_empty_scheduler();
    send_tick();
    send_tick();
  endtask

  task automatic test_extreme_records();
    send_item(FUNC_LOAD, 4'd15, '1, '1, '1);
    send_tick();
    send_item(FUNC_LOAD, 4'd0, '0, 16'd1, '0);
    send_tick();
    // A zero burst finishes the task at once.
    send_item(FUNC_LOAD, 4'd15, '0, '0, '0);
    send_tick();
    send_item(FUNC_LOAD, 4'd1, '0, '1, '0);
    send_tick();
    send_item(FUNC_LOAD, 4'd1, '1, '0, '1);
  endtask

  task automatic test_preemption_and_ties();
    // A higher priority arrival takes over, then the first task resumes.
    send_item(FUNC_LOAD, 4'd7, sched_now, 16'd2, 8'd10);
    send_tick();
    send_item(FUNC_LOAD, 4'd8, sched_now, 16'd1, 8'd20);
    send_tick();
    send_tick();
    // Equal priority: the earlier arrival first, then the lower slot.
    send_item(FUNC_LOAD, 4'd9, sched_now, 16'd1, 8'd80);
    send_item(FUNC_LOAD, 4'd3, sched_now, 16'd1, 8'd80);
    send_item(FUNC_LOAD, 4'd12, sched_now - 1'b1, 16'd1, 8'd80);
    repeat (3) send_tick();
    // A reload restarts the task with its full burst.
    send_item(FUNC_LOAD, 4'd4, sched_now, 16'd3, 8'd5);
    send_tick();
    send_item(FUNC_LOAD, 4'd4, sched_now, 16'd2, 8'd5);
    send_tick();
    send_tick();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (3) run_batch();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_workloads();
    int choice;
    while (items_sent < 730) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        run_batch();
        no_gaps = 1'b0;
      end else if (choice < 85) begin
        // Noise: full-range records that mostly never arrive or never end.
        repeat ($urandom_range(1, 3))
          send_item(FUNC_LOAD, SLOT_W'($urandom), TIME_BITS'($urandom),
                    TIME_BITS'($urandom_range(1, 65535)), PRIO_W'($urandom));
      end else if (choice < 95) begin
        retire_stale();
      end else begin
        wait_for_results();
      end
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.running_slot = m_tdata[3:0];
      got.idle         = m_tdata[4];
      got.finished     = m_tdata[5];
      got.completion   = m_tdata[21:6];
      got.turnaround   = m_tdata[37:22];
      got.waiting      = m_tdata[53:38];
      got.all_done     = m_tdata[54];
      n_checked++;
      if (pending_results.size() == 0) begin
        report_bad("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_bad("mismatch", want, got);
      end
    end
  end

  // Result sink with random stalls before each transaction, or none if no_gaps is set.
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tuser  = FUNC_LOAD;
    s_tdata  = '0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      task_loaded[k]  = 1'b0;
      task_done[k]    = 1'b0;
      task_arrival[k] = '0;
      task_burst[k]   = '0;
      task_remain[k]  = '0;
      task_prio[k]    = '0;
    end
    sched_now = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_scheduler();
    test_extreme_records();
    test_preemption_and_ties();
    wait_for_results();
    test_back_to_back();
    wait_for_results();
    test_random_workloads();
    retire_stale();

    // Drain the outstanding results, then watch for strays.
    wait_for_results();
    repeat (40) @(posedge clk);

    $display("Run covered %0d loads and %0d ticks, %0d task completions, %0d idle ticks.",
             n_loads, n_ticks, n_finish, n_idle);
    $display("Checked %0d results with %0d failures.", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
